// File: rtl/core/pbra_pkg.sv
// shared types and constants for the page bitmap run allocator
// no dependencies
package pbra_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int MAX_RUN   = 64;
    localparam int REF_WIDTH = 16;
    localparam int PG_W      = 12;
    localparam int WORDS     = NUM_PAGES / 64;
    localparam int WORD_W    = 6;
    localparam int TOT_W     = 13;
    localparam int TREF_W    = 16;

    localparam logic [TOT_W-1:0]     TOT_MAX  = TOT_W'(NUM_PAGES);
    localparam logic [TREF_W-1:0]    TREF_MAX = '1;
    localparam logic [REF_WIDTH-1:0] REF_MAX  = '1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_CLEAN = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SRD,
        S_SCAN,
        S_RD,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TOT_W-1:0]  free_cnt;
        logic [TOT_W-1:0]  used_cnt;
        logic [TREF_W-1:0] ref_cnt;
    } t_totals;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           attr;
        logic [REF_WIDTH-1:0] refs;
        logic                 used;
        logic [7:0]           flags;
    } t_page_in;

    typedef struct packed {
        logic [7:0]           attr;
        logic [REF_WIDTH-1:0] refs;
        logic                 used;
    } t_page_out;

endpackage

// File: rtl/core/pbra_page_rule.sv
// per-page update rule: mark, clean and add_free on one page and the totals
// depends on pbra_pkg
module pbra_page_rule (
    input  pbra_pkg::t_page_in  i_page,
    input  pbra_pkg::t_totals   i_tot,
    output pbra_pkg::t_page_out o_page,
    output pbra_pkg::t_totals   o_tot
);
    import pbra_pkg::*;

    logic [REF_WIDTH-1:0] refs_dec;

    assign refs_dec = (i_page.refs != '0) ? i_page.refs - 1'b1 : i_page.refs;

    always_comb begin
        o_page.attr = i_page.attr;
        o_page.refs = i_page.refs;
        o_page.used = i_page.used;
        o_tot       = i_tot;
        unique case (i_page.op)
            OP_ALLOC, OP_MARK: begin
                if (i_page.attr == 8'd0) begin
                    o_page.used = 1'b1;
                    o_page.attr = i_page.flags;
                    if (i_page.refs != REF_MAX) o_page.refs = i_page.refs + 1'b1;
                    if (i_tot.used_cnt < TOT_MAX) o_tot.used_cnt = i_tot.used_cnt + 1'b1;
                    if (i_tot.free_cnt != '0) o_tot.free_cnt = i_tot.free_cnt - 1'b1;
                    if (i_tot.ref_cnt != TREF_MAX) o_tot.ref_cnt = i_tot.ref_cnt + 1'b1;
                end else if (((i_page.attr | i_page.flags) & 8'd3) != 8'd0) begin
                    o_page.attr = i_page.attr | i_page.flags;
                    if (i_page.refs != REF_MAX) o_page.refs = i_page.refs + 1'b1;
                    if (i_tot.ref_cnt != TREF_MAX) o_tot.ref_cnt = i_tot.ref_cnt + 1'b1;
                end else begin
                    o_page.used = 1'b1;
                    o_page.attr = i_page.attr | i_page.flags;
                end
            end
            OP_CLEAN: begin
                if (i_page.attr == 8'd0) begin
                    o_page = '{attr: i_page.attr, refs: i_page.refs, used: i_page.used};
                end else if ((i_page.attr & 8'd3) != 8'd0) begin
                    o_page.refs = refs_dec;
                    if (i_tot.ref_cnt != '0) o_tot.ref_cnt = i_tot.ref_cnt - 1'b1;
                    // last reference gone: page goes back to free
                    if (refs_dec == '0) begin
                        o_page.attr = 8'd0;
                        o_page.used = 1'b0;
                        if (i_tot.used_cnt != '0) o_tot.used_cnt = i_tot.used_cnt - 1'b1;
                        if (i_tot.free_cnt < TOT_MAX) o_tot.free_cnt = i_tot.free_cnt + 1'b1;
                    end
                end else begin
                    o_page.used = 1'b0;
                    o_page.attr = 8'd0;
                    o_page.refs = '0;
                    if (i_tot.free_cnt < TOT_MAX) o_tot.free_cnt = i_tot.free_cnt + 1'b1;
                    if (i_tot.used_cnt != '0) o_tot.used_cnt = i_tot.used_cnt - 1'b1;
                    if (i_tot.ref_cnt != '0) o_tot.ref_cnt = i_tot.ref_cnt - 1'b1;
                end
            end
            OP_FREE: begin
                if (i_page.used) begin
                    o_page.used = 1'b0;
                    if (i_tot.free_cnt < TOT_MAX) o_tot.free_cnt = i_tot.free_cnt + 1'b1;
                end
                o_page.attr = 8'd0;
                o_page.refs = '0;
            end
            default: begin
                o_tot = i_tot;
            end
        endcase
    end

endmodule

// File: rtl/core/page_bitmap_run_allocator.sv
// page bitmap run allocator: mark, clean, add_free one page; alloc a run in a range
// sequence: mark/clean/add_free read the page, then update it; alloc reads each bitmap
// word entered and scans its pages, then reads and updates each run page (unless rejected);
// all pages go through one page rule unit
// throughput: one request at a time, next request taken once the sequencer is idle
// reset: synchronous active low; a clearing pass then sweeps the memories
// depends on pbra_pkg, pbra_page_rule
module page_bitmap_run_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [11:0] i_page_index,
    input  logic [6:0] i_run_length,
    input  logic [11:0] i_search_start,
    input  logic [11:0] i_search_end,
    input  logic [7:0] i_attr_flags,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_ok,
    output logic [11:0] o_found_page,
    output logic [12:0] o_free_pages,
    output logic [12:0] o_used_pages,
    output logic [15:0] o_total_refs
);
    import pbra_pkg::*;

    logic [63:0]          mem_map  [WORDS];
    logic [7:0]           mem_attr [NUM_PAGES];
    logic [REF_WIDTH-1:0] mem_refs [NUM_PAGES];

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [PG_W-1:0] r_pg, n_pg, r_hi, n_hi, r_start, n_start, r_clr, n_clr;
    logic [6:0] r_n, n_n, r_len, n_len;
    logic [7:0] r_flags, n_flags;
    logic       r_res_ok, n_res_ok;
    t_totals    r_tot, n_tot;

    logic [63:0]          r_map_q;
    logic [7:0]           r_attr_q;
    logic [REF_WIDTH-1:0] r_refs_q;

    logic        r_out_valid, n_out_valid;
    logic        r_ok;
    logic [11:0] r_found;
    t_totals     r_out_tot;
    logic        load_out;

    t_page_in  rule_in;
    t_page_out rule_out;
    t_totals   rule_tot;

    logic        we_page;
    logic [63:0] map_wdata;
    logic        scan_bit;
    logic [6:0]  len_inc;
    logic [TOT_W-1:0] span;
    logic        accept;

    assign accept = i_valid && !o_stall;

    assign rule_in = '{op: r_op, attr: r_attr_q, refs: r_refs_q,
                       used: r_map_q[r_pg[WORD_W-1:0]], flags: r_flags};

    pbra_page_rule u_rule (
        .i_page (rule_in),
        .i_tot  (r_tot),
        .o_page (rule_out),
        .o_tot  (rule_tot)
    );

    always_comb begin
        map_wdata = r_map_q;
        map_wdata[r_pg[WORD_W-1:0]] = rule_out.used;
    end

    assign scan_bit = r_map_q[r_pg[WORD_W-1:0]];
    assign len_inc  = r_len + 7'd1;
    assign span     = {1'b0, i_search_end} - {1'b0, i_search_start} + 13'd1;

    // memories: one read at the current page every cycle, one write port
    always_ff @(posedge i_clk) begin
        r_map_q  <= mem_map[r_pg[PG_W-1:WORD_W]];
        r_attr_q <= mem_attr[r_pg];
        r_refs_q <= mem_refs[r_pg];
        if (r_state == S_CLR) begin
            mem_map[r_clr[WORD_W-1:0]] <= '1;
            mem_attr[r_clr] <= 8'd0;
            mem_refs[r_clr] <= '0;
        end else if (we_page) begin
            mem_map[r_pg[PG_W-1:WORD_W]] <= map_wdata;
            mem_attr[r_pg] <= rule_out.attr;
            mem_refs[r_pg] <= rule_out.refs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_tot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_tot       <= n_tot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pg     <= n_pg;
        r_hi     <= n_hi;
        r_start  <= n_start;
        r_n      <= n_n;
        r_len    <= n_len;
        r_flags  <= n_flags;
        r_res_ok <= n_res_ok;
        if (load_out) begin
            r_ok      <= r_res_ok;
            r_found   <= r_res_ok && (r_op == OP_ALLOC) ? r_start : 12'd0;
            r_out_tot <= r_tot;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pg     = r_pg;
        n_hi     = r_hi;
        n_start  = r_start;
        n_n      = r_n;
        n_len    = r_len;
        n_flags  = r_flags;
        n_res_ok = r_res_ok;
        n_clr    = r_clr;
        n_tot    = r_tot;
        we_page  = 1'b0;
        load_out = 1'b0;
        o_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == PG_W'(NUM_PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_op);
                    n_flags  = i_attr_flags;
                    n_n      = i_run_length;
                    n_hi     = i_search_end;
                    n_len    = 7'd0;
                    n_res_ok = 1'b1;
                    if (t_op'(i_op) == OP_ALLOC) begin
                        n_pg    = i_search_start;
                        n_start = i_search_start;
                        if (i_run_length == 7'd0 || i_run_length > 7'(MAX_RUN)
                            || i_search_start > i_search_end
                            || span < {6'd0, i_run_length}
                            || r_tot.free_cnt < {6'd0, i_run_length}) begin
                            n_res_ok = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SRD;
                        end
                    end else begin
                        n_pg    = i_page_index;
                        n_start = i_page_index;
                        n_n     = 7'd1;
                        n_state = S_RD;
                    end
                end
            end
            S_SRD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_len = scan_bit ? 7'd0 : len_inc;
                if (!scan_bit && len_inc == r_n) begin
                    // first completed run has the lowest start
                    n_start = r_pg + 12'd1 - {5'd0, r_n};
                    n_pg    = r_pg + 12'd1 - {5'd0, r_n};
                    n_state = S_RD;
                end else if (r_pg == r_hi) begin
                    n_res_ok = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_pg = r_pg + 12'd1;
                    if (r_pg[WORD_W-1:0] == '1) n_state = S_SRD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                we_page = 1'b1;
                n_tot   = rule_tot;
                n_n     = r_n - 7'd1;
                if (r_n == 7'd1) begin
                    n_state = S_DONE;
                end else begin
                    n_pg    = r_pg + 12'd1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (load_out) n_out_valid = 1'b1;
        else if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_found_page = r_found;
    assign o_free_pages = r_out_tot.free_cnt;
    assign o_used_pages = r_out_tot.used_cnt;
    assign o_total_refs = r_out_tot.ref_cnt;

    a_clr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_valid) else $error("result during clearing pass");
    a_upd_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $past(r_state) == S_RD) else $error("update without read");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot.free_cnt <= TOT_MAX && r_tot.used_cnt <= TOT_MAX)
        else $error("page total above page count");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_stall) |=> r_state == S_DONE)
        else $error("result dropped while output stalled");

endmodule
